// ===== rtl/gsa_pkg.sv =====
`default_nettype none

package gsa_pkg;

  // fixed field widths
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned GEN_W  = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned ACT_W  = 3;

  // action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_SPAWN   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DESTROY = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POS     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_AT      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEND    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_COMPACT = 3'd5;

  // decoded operation
  typedef enum logic [2:0] {
    OP_SPAWN,
    OP_DESTROY,
    OP_POS,
    OP_AT,
    OP_PEND,
    OP_COMPACT,
    OP_NOP
  } op_t;

  // back end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SP0,
    ST_SP1,
    ST_SP2,
    ST_H0,
    ST_H1,
    ST_H2,
    ST_Q0,
    ST_Q1,
    ST_Q2,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_CEND,
    ST_FAIL
  } state_t;

  // classified command, front to back
  typedef struct packed {
    op_t               op;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  generation;
    logic [POS_W-1:0]  dense_pos;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] out_slot;
    logic [GEN_W-1:0]  out_generation;
    logic [POS_W-1:0]  out_dense_pos;
    logic              moved;
    logic [POS_W-1:0]  move_from;
    logic [POS_W-1:0]  move_to;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/generational_slot_allocator.sv =====
// Channel  Dir  tvalid/tready          tdata / tuser / tlast
// in_      in   in_tvalid, in_tready   tdata: slot, generation, dense_pos; tuser: action
// out_     out  out_tvalid, out_tready tdata: ok .. move_to; tuser: moved; tlast: last
//
// Spawn, destroy and the queries run through the registered read of the slot
// tables and the chain of lookups (stack or handle, then link); a spawn on a full map,
// an out-of-range position query or an unused action goes straight to the failure result.
// Compact walks the positions from the top down: a pending entry below the last position
// is first filled by the last entry and the move reported, then the pending slot is retired.
// Reset is synchronous and active low; the generation, slot-to-position and free stack
// contents are qualified by valid bits, so no clearing pass is needed.
// The two-entry command queue keeps accepting, until it is full, while a result waits on out_tready.
`default_nettype none

module generational_slot_allocator #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // slot[5:0], generation[37:6], dense_pos[43:38]
  input  wire logic [2:0]  in_tuser,   // action[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // ok[0], out_slot[6:1], out_generation[38:7],
                                       // out_dense_pos[44:39], move_from[50:45],
                                       // move_to[56:51]
  output logic [0:0]       out_tuser,  // moved[0]
  output logic             out_tlast
);

  gsa_pkg::cmd_t push_cmd, pop_cmd;
  gsa_pkg::res_t res;
  logic          q_full, q_push, q_pop, q_avail;

  gsa_front #(.CAPACITY(CAPACITY)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  gsa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_cmd  (pop_cmd)
  );

  gsa_back #(.CAPACITY(CAPACITY)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_avail   (q_avail),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // result packing
  assign out_tdata = {7'd0, res.move_to, res.move_from, res.out_dense_pos,
                      res.out_generation, res.out_slot, res.ok};
  assign out_tuser = res.moved;
  assign out_tlast = res.last;

endmodule

`default_nettype wire

// ===== rtl/gsa_queue.sv =====
`default_nettype none

// two-entry command queue between front and back
module gsa_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  gsa_pkg::cmd_t      push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               avail,
  output gsa_pkg::cmd_t      pop_cmd
);

  gsa_pkg::cmd_t ent_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign avail   = (cnt_r != 2'd0);
  assign pop_cmd = ent_r[rp_r];

  // pointer and count update
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gsa_front.sv =====
`default_nettype none

// accepts input transactions, decodes the action and range-checks the slot
module gsa_front #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [47:0]                 in_tdata,
  input  wire logic [gsa_pkg::ACT_W-1:0]   in_tuser,
  input  wire logic                        q_full,
  output logic                             q_push,
  output gsa_pkg::cmd_t                    q_cmd
);

  localparam logic [gsa_pkg::SLOT_W:0] CAP_X = (gsa_pkg::SLOT_W + 1)'(CAPACITY);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // classify
  always_comb begin
    q_cmd.slot       = in_tdata[5:0];
    q_cmd.generation = in_tdata[37:6];
    q_cmd.dense_pos  = in_tdata[43:38];
    q_cmd.slot_ok    = ({1'b0, in_tdata[5:0]} < CAP_X);
    case (in_tuser)
      gsa_pkg::ACT_SPAWN:   q_cmd.op = gsa_pkg::OP_SPAWN;
      gsa_pkg::ACT_DESTROY: q_cmd.op = gsa_pkg::OP_DESTROY;
      gsa_pkg::ACT_POS:     q_cmd.op = gsa_pkg::OP_POS;
      gsa_pkg::ACT_AT:      q_cmd.op = gsa_pkg::OP_AT;
      gsa_pkg::ACT_PEND:    q_cmd.op = gsa_pkg::OP_PEND;
      gsa_pkg::ACT_COMPACT: q_cmd.op = gsa_pkg::OP_COMPACT;
      default:              q_cmd.op = gsa_pkg::OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/gsa_back.sv =====
`default_nettype none

// executes commands against the slot tables and drives the result register
module gsa_back #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_avail,
  input  gsa_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output gsa_pkg::res_t out_res
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [AW-1:0] TOP_I = AW'(CAPACITY - 1);
  localparam logic [gsa_pkg::POS_W:0] CAP_X = (gsa_pkg::POS_W + 1)'(CAPACITY);

  // tables
  logic [gsa_pkg::GEN_W-1:0] gen_mem [CAPACITY];
  logic [AW:0]               s2p_mem [CAPACITY];
  logic [AW-1:0]             p2s_mem [CAPACITY];
  logic [AW-1:0]             fs_mem  [CAPACITY];

  logic [CAPACITY-1:0] gen_vld_r, s2p_vld_r, fs_vld_r, pend_r;
  logic [CAPACITY-1:0] gen_vld_nxt, s2p_vld_nxt, fs_vld_nxt, pend_nxt;

  // table ports
  logic                      gen_re, gen_we, s2p_re, s2p_we, p2s_re, p2s_we, fs_re, fs_we;
  logic [AW-1:0]             gen_ra, gen_wa, s2p_ra, s2p_wa, p2s_ra, p2s_wa, fs_ra, fs_wa;
  logic [gsa_pkg::GEN_W-1:0] gen_wd, gen_q;
  logic [AW:0]               s2p_wd, s2p_q;
  logic [AW-1:0]             p2s_wd, p2s_q, fs_wd, fs_q, fs_qi;
  logic                      gen_qv, s2p_qv, fs_qv;

  // control state
  gsa_pkg::state_t state_r, state_nxt;
  gsa_pkg::cmd_t   cmd_r, cmd_nxt;
  gsa_pkg::res_t   res_r, res_nxt;
  logic            out_v_r, out_v_nxt;
  logic [CW-1:0]   live_r, live_nxt, free_r, free_nxt, pcnt_r, pcnt_nxt, cnt_r, cnt_nxt;
  logic [AW-1:0]   cur_s_r, cur_s_nxt, hp_r, hp_nxt;
  logic            held_v_r, held_v_nxt;
  logic [AW-1:0]   held_from_r, held_from_nxt, held_to_r, held_to_nxt;

  // decoded read data
  logic [gsa_pkg::GEN_W-1:0] gen_rd, gen_inc;
  logic                      s2p_none, out_free, h_live;
  logic [AW-1:0]             s2p_pos, fs_rd, cslot, pos_c, last_c;

  always_comb begin
    gen_rd   = gen_qv ? gen_q : gsa_pkg::GEN_W'(1);
    gen_inc  = gen_rd + gsa_pkg::GEN_W'(1);
    if (gen_inc == '0) begin
      gen_inc = gsa_pkg::GEN_W'(1);
    end
    s2p_none = !s2p_qv || s2p_q[AW];
    s2p_pos  = s2p_q[AW-1:0];
    fs_rd    = fs_qv ? fs_q : TOP_I - fs_qi;
    cslot    = cmd_r.slot[AW-1:0];
    pos_c    = AW'(cnt_r - CW'(1));
    last_c   = AW'(live_r - CW'(1));
    h_live   = (p2s_q == cslot);
    out_free = !out_v_r || out_ready;
  end

  assign q_pop     = (state_r == gsa_pkg::ST_IDLE) && q_avail;
  assign out_valid = out_v_r;
  assign out_res   = res_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    res_nxt       = res_r;
    out_v_nxt     = out_v_r && !out_ready;
    live_nxt      = live_r;
    free_nxt      = free_r;
    pcnt_nxt      = pcnt_r;
    cnt_nxt       = cnt_r;
    cur_s_nxt     = cur_s_r;
    hp_nxt        = hp_r;
    held_v_nxt    = held_v_r;
    held_from_nxt = held_from_r;
    held_to_nxt   = held_to_r;
    gen_vld_nxt   = gen_vld_r;
    s2p_vld_nxt   = s2p_vld_r;
    fs_vld_nxt    = fs_vld_r;
    pend_nxt      = pend_r;
    gen_re = 1'b0; gen_we = 1'b0; gen_ra = '0; gen_wa = '0; gen_wd = '0;
    s2p_re = 1'b0; s2p_we = 1'b0; s2p_ra = '0; s2p_wa = '0; s2p_wd = '0;
    p2s_re = 1'b0; p2s_we = 1'b0; p2s_ra = '0; p2s_wa = '0; p2s_wd = '0;
    fs_re  = 1'b0; fs_we  = 1'b0; fs_ra  = '0; fs_wa  = '0; fs_wd  = '0;

    case (state_r)
      gsa_pkg::ST_IDLE: begin
        if (q_avail) begin
          cmd_nxt = q_cmd;
          case (q_cmd.op)
            gsa_pkg::OP_SPAWN:   state_nxt = gsa_pkg::ST_SP0;
            gsa_pkg::OP_DESTROY,
            gsa_pkg::OP_POS,
            gsa_pkg::OP_PEND:    state_nxt = gsa_pkg::ST_H0;
            gsa_pkg::OP_AT:      state_nxt = gsa_pkg::ST_Q0;
            gsa_pkg::OP_COMPACT: begin
              cnt_nxt    = live_r;
              held_v_nxt = 1'b0;
              state_nxt  = gsa_pkg::ST_C0;
            end
            default:             state_nxt = gsa_pkg::ST_FAIL;
          endcase
        end
      end

      // spawn: pop free stack, read generation, link both tables
      gsa_pkg::ST_SP0: begin
        if (free_r == '0 || live_r >= CAP_C) begin
          state_nxt = gsa_pkg::ST_FAIL;
        end else begin
          fs_re     = 1'b1;
          fs_ra     = AW'(free_r - CW'(1));
          state_nxt = gsa_pkg::ST_SP1;
        end
      end
      gsa_pkg::ST_SP1: begin
        gen_re    = 1'b1;
        gen_ra    = fs_rd;
        cur_s_nxt = fs_rd;
        state_nxt = gsa_pkg::ST_SP2;
      end
      gsa_pkg::ST_SP2: begin
        if (out_free) begin
          s2p_we  = 1'b1;
          s2p_wa  = cur_s_r;
          s2p_wd  = {1'b0, AW'(live_r)};
          s2p_vld_nxt[cur_s_r] = 1'b1;
          p2s_we  = 1'b1;
          p2s_wa  = AW'(live_r);
          p2s_wd  = cur_s_r;
          live_nxt = live_r + CW'(1);
          free_nxt = free_r - CW'(1);
          res_nxt = '0;
          res_nxt.ok             = 1'b1;
          res_nxt.out_slot       = gsa_pkg::SLOT_W'(cur_s_r);
          res_nxt.out_generation = gen_rd;
          res_nxt.out_dense_pos  = gsa_pkg::POS_W'(live_r);
          res_nxt.last           = 1'b1;
          out_v_nxt = 1'b1;
          state_nxt = gsa_pkg::ST_IDLE;
        end
      end

      // handle check: generation, position, back link
      gsa_pkg::ST_H0: begin
        if (!cmd_r.slot_ok) begin
          state_nxt = gsa_pkg::ST_FAIL;
        end else begin
          gen_re    = 1'b1;
          gen_ra    = cslot;
          s2p_re    = 1'b1;
          s2p_ra    = cslot;
          state_nxt = gsa_pkg::ST_H1;
        end
      end
      gsa_pkg::ST_H1: begin
        if (gen_rd != cmd_r.generation || s2p_none || CW'(s2p_pos) >= live_r) begin
          state_nxt = gsa_pkg::ST_FAIL;
        end else begin
          p2s_re    = 1'b1;
          p2s_ra    = s2p_pos;
          hp_nxt    = s2p_pos;
          state_nxt = gsa_pkg::ST_H2;
        end
      end
      gsa_pkg::ST_H2: begin
        if (out_free) begin
          res_nxt      = '0;
          res_nxt.last = 1'b1;
          case (cmd_r.op)
            gsa_pkg::OP_DESTROY: begin
              if (h_live && !pend_r[cslot]) begin
                pend_nxt[cslot] = 1'b1;
                pcnt_nxt        = pcnt_r + CW'(1);
                res_nxt.ok      = 1'b1;
              end
            end
            gsa_pkg::OP_POS: begin
              res_nxt.ok = h_live;
              if (h_live) begin
                res_nxt.out_dense_pos = gsa_pkg::POS_W'(hp_r);
              end
            end
            gsa_pkg::OP_PEND: res_nxt.ok = h_live && pend_r[cslot];
            default:          res_nxt.ok = 1'b0;
          endcase
          out_v_nxt = 1'b1;
          state_nxt = gsa_pkg::ST_IDLE;
        end
      end

      // handle at position
      gsa_pkg::ST_Q0: begin
        if ({1'b0, cmd_r.dense_pos} >= CAP_X ||
            CW'(cmd_r.dense_pos) >= live_r) begin
          state_nxt = gsa_pkg::ST_FAIL;
        end else begin
          p2s_re    = 1'b1;
          p2s_ra    = cmd_r.dense_pos[AW-1:0];
          state_nxt = gsa_pkg::ST_Q1;
        end
      end
      gsa_pkg::ST_Q1: begin
        gen_re    = 1'b1;
        gen_ra    = p2s_q;
        cur_s_nxt = p2s_q;
        state_nxt = gsa_pkg::ST_Q2;
      end
      gsa_pkg::ST_Q2: begin
        if (out_free) begin
          res_nxt = '0;
          res_nxt.ok             = 1'b1;
          res_nxt.out_slot       = gsa_pkg::SLOT_W'(cur_s_r);
          res_nxt.out_generation = gen_rd;
          res_nxt.out_dense_pos  = cmd_r.dense_pos;
          res_nxt.last           = 1'b1;
          out_v_nxt = 1'b1;
          state_nxt = gsa_pkg::ST_IDLE;
        end
      end

      // compact: walk positions from the top down
      gsa_pkg::ST_C0: begin
        if (cnt_r == '0) begin
          state_nxt = gsa_pkg::ST_CEND;
        end else begin
          p2s_re    = 1'b1;
          p2s_ra    = pos_c;
          state_nxt = gsa_pkg::ST_C1;
        end
      end
      gsa_pkg::ST_C1: begin
        cur_s_nxt = p2s_q;
        if (!pend_r[p2s_q]) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = gsa_pkg::ST_C0;
        end else begin
          gen_re = 1'b1;
          gen_ra = p2s_q;
          if (cnt_r != live_r) begin
            p2s_re    = 1'b1;
            p2s_ra    = last_c;
            state_nxt = gsa_pkg::ST_C2;
          end else begin
            state_nxt = gsa_pkg::ST_C3;
          end
        end
      end
      gsa_pkg::ST_C2: begin
        // last entry fills the gap; previous move goes out now
        if (!held_v_r || out_free) begin
          if (held_v_r) begin
            res_nxt           = '0;
            res_nxt.moved     = 1'b1;
            res_nxt.move_from = gsa_pkg::POS_W'(held_from_r);
            res_nxt.move_to   = gsa_pkg::POS_W'(held_to_r);
            out_v_nxt         = 1'b1;
          end
          held_v_nxt    = 1'b1;
          held_from_nxt = last_c;
          held_to_nxt   = pos_c;
          p2s_we = 1'b1;
          p2s_wa = pos_c;
          p2s_wd = p2s_q;
          s2p_we = 1'b1;
          s2p_wa = p2s_q;
          s2p_wd = {1'b0, pos_c};
          s2p_vld_nxt[p2s_q] = 1'b1;
          state_nxt = gsa_pkg::ST_C3;
        end
      end
      gsa_pkg::ST_C3: begin
        // retire the removed slot
        gen_we = 1'b1;
        gen_wa = cur_s_r;
        gen_wd = gen_inc;
        gen_vld_nxt[cur_s_r] = 1'b1;
        s2p_we = 1'b1;
        s2p_wa = cur_s_r;
        s2p_wd = {1'b1, AW'(0)};
        s2p_vld_nxt[cur_s_r] = 1'b1;
        pend_nxt[cur_s_r]    = 1'b0;
        live_nxt = live_r - CW'(1);
        if (free_r < CAP_C) begin
          fs_we = 1'b1;
          fs_wa = AW'(free_r);
          fs_wd = cur_s_r;
          fs_vld_nxt[AW'(free_r)] = 1'b1;
          free_nxt = free_r + CW'(1);
        end
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = gsa_pkg::ST_C0;
      end
      gsa_pkg::ST_CEND: begin
        if (out_free) begin
          res_nxt = '0;
          if (held_v_r) begin
            res_nxt.moved     = 1'b1;
            res_nxt.move_from = gsa_pkg::POS_W'(held_from_r);
            res_nxt.move_to   = gsa_pkg::POS_W'(held_to_r);
          end
          res_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
          held_v_nxt   = 1'b0;
          pcnt_nxt     = '0;
          state_nxt    = gsa_pkg::ST_IDLE;
        end
      end

      gsa_pkg::ST_FAIL: begin
        if (out_free) begin
          res_nxt      = '0;
          res_nxt.last = 1'b1;
          out_v_nxt    = 1'b1;
          state_nxt    = gsa_pkg::ST_IDLE;
        end
      end

      default: state_nxt = gsa_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gsa_pkg::ST_IDLE;
      out_v_r   <= 1'b0;
      live_r    <= '0;
      free_r    <= CAP_C;
      pcnt_r    <= '0;
      cnt_r     <= '0;
      held_v_r  <= 1'b0;
      gen_vld_r <= '0;
      s2p_vld_r <= '0;
      fs_vld_r  <= '0;
      pend_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      out_v_r   <= out_v_nxt;
      live_r    <= live_nxt;
      free_r    <= free_nxt;
      pcnt_r    <= pcnt_nxt;
      cnt_r     <= cnt_nxt;
      held_v_r  <= held_v_nxt;
      gen_vld_r <= gen_vld_nxt;
      s2p_vld_r <= s2p_vld_nxt;
      fs_vld_r  <= fs_vld_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    res_r       <= res_nxt;
    cur_s_r     <= cur_s_nxt;
    hp_r        <= hp_nxt;
    held_from_r <= held_from_nxt;
    held_to_r   <= held_to_nxt;
  end

  // generation table
  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (gen_re) begin
      gen_q  <= gen_mem[gen_ra];
      gen_qv <= gen_vld_r[gen_ra];
    end
  end

  // slot to position table
  always_ff @(posedge clk) begin
    if (s2p_we) begin
      s2p_mem[s2p_wa] <= s2p_wd;
    end
    if (s2p_re) begin
      s2p_q  <= s2p_mem[s2p_ra];
      s2p_qv <= s2p_vld_r[s2p_ra];
    end
  end

  // position to slot table
  always_ff @(posedge clk) begin
    if (p2s_we) begin
      p2s_mem[p2s_wa] <= p2s_wd;
    end
    if (p2s_re) begin
      p2s_q <= p2s_mem[p2s_ra];
    end
  end

  // free stack
  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_wa] <= fs_wd;
    end
    if (fs_re) begin
      fs_q  <= fs_mem[fs_ra];
      fs_qv <= fs_vld_r[fs_ra];
      fs_qi <= fs_ra;
    end
  end

  // every slot is either free or live
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + 1)'(live_r) + (CW + 1)'(free_r) == (CW + 1)'(CAPACITY))
    else $error("live and free counts out of balance");

  // outside a compaction, pending entries are a subset of live ones
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gsa_pkg::ST_IDLE) |-> (pcnt_r <= live_r))
    else $error("pending count above live count");

  // compaction ends with an empty pending set and no held move
  a_cend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gsa_pkg::ST_CEND && out_free) |=>
      (state_r == gsa_pkg::ST_IDLE && pcnt_r == '0 && !held_v_r && out_v_r && res_r.last))
    else $error("compaction did not close cleanly");

  // a result that reports a move never carries ok
  a_move_only_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.moved) |-> (res_r.ok == 1'b0))
    else $error("move result carries ok");

endmodule

`default_nettype wire

// ===== tb/sv/generational_slot_allocator_tb.sv =====
`timescale 1ns / 1ps

module generational_slot_allocator_tb;

  localparam int CAP = 64;
  localparam logic [6:0] NO_POS = 7'd127;
  // action codes the block leaves unused
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // slot[5:0], generation[37:6], dense_pos[43:38]
  logic [2:0]  in_tuser;   // action[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // ok, out_slot, out_generation, out_dense_pos, move_from, move_to
  logic [0:0]  out_tuser;  // moved
  logic        out_tlast;

  generational_slot_allocator #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // shadow copy of the slot map
  logic [31:0] gen_of [CAP];
  logic [6:0]  pos_of [CAP];
  logic [5:0]  slot_at [CAP];
  logic        pend [CAP];
  logic [5:0]  free_stk [CAP];
  int          n_free, n_live;

  gsa_pkg::res_t exp_q[$];
  int   n_err, n_items, n_res, n_moves, n_spawn_full;
  bit   hold_long;
  bit   rx_pattern_on;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic gsa_pkg::res_t blank_res();
    gsa_pkg::res_t r;
    r = '0;
    r.last = 1'b1;
    return r;
  endfunction

  // append one expected result
  function automatic void queue_expected(gsa_pkg::res_t r);
    exp_q.insert(exp_q.size(), r);
  endfunction

  function automatic bit is_live(logic [5:0] s, logic [31:0] g);
    logic [6:0] p;
    p = pos_of[s];
    if (gen_of[s] != g) return 0;
    return p < n_live && p < CAP && slot_at[p[5:0]] == s;
  endfunction

  // compute results of one transaction and update the shadow map
  task automatic predict_map(logic [2:0] act, logic [5:0] s, logic [31:0] g, logic [5:0] dp);
    gsa_pkg::res_t r;
    logic [5:0] sl, ms, lastp;
    int nmv;
    r = blank_res();
    case (act)
      gsa_pkg::ACT_SPAWN: begin
        if (n_free > 0 && n_live < CAP) begin
          n_free--;
          sl = free_stk[n_free];
          pos_of[sl] = 7'(n_live);
          slot_at[n_live] = sl;
          r.ok = 1; r.out_slot = sl; r.out_generation = gen_of[sl];
          r.out_dense_pos = 6'(n_live);
          n_live++;
        end else n_spawn_full++;
        queue_expected(r);
      end
      gsa_pkg::ACT_DESTROY: begin
        if (is_live(s, g) && !pend[s]) begin
          pend[s] = 1; r.ok = 1;
        end
        queue_expected(r);
      end
      gsa_pkg::ACT_POS: begin
        if (is_live(s, g)) begin
          r.ok = 1; r.out_dense_pos = pos_of[s][5:0];
        end
        queue_expected(r);
      end
      gsa_pkg::ACT_AT: begin
        if (dp < n_live) begin
          sl = slot_at[dp];
          r.ok = 1; r.out_slot = sl; r.out_generation = gen_of[sl]; r.out_dense_pos = dp;
        end
        queue_expected(r);
      end
      gsa_pkg::ACT_PEND: begin
        r.ok = is_live(s, g) && pend[s];
        queue_expected(r);
      end
      gsa_pkg::ACT_COMPACT: begin
        nmv = 0;
        for (int p = n_live - 1; p >= 0; p--) begin
          sl = slot_at[p];
          if (pend[sl]) begin
            lastp = 6'(n_live - 1);
            if (p != n_live - 1) begin
              ms = slot_at[lastp];
              slot_at[p] = ms;
              pos_of[ms] = 7'(p);
              r = '0; r.moved = 1; r.move_from = lastp; r.move_to = 6'(p);
              queue_expected(r);
              nmv++; n_moves++;
            end
            n_live--;
            pend[sl] = 0;
            gen_of[sl] = gen_of[sl] + 1;
            if (gen_of[sl] == 0) gen_of[sl] = 1;
            pos_of[sl] = NO_POS;
            if (n_free < CAP) begin
              free_stk[n_free] = sl;
              n_free++;
            end
          end
        end
        if (nmv == 0) queue_expected(blank_res());
        else exp_q[$].last = 1'b1;
      end
      default: queue_expected(blank_res());
    endcase
  endtask

  // send one transaction; prediction happens at acceptance
  task automatic send_op(logic [2:0] act, logic [5:0] s, logic [31:0] g, logic [5:0] dp);
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {4'd0, dp, g, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_map(act, s, g, dp);
    n_items++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // bursty sender gap
  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (exp_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
  endtask

  // pick a handle: mostly live, sometimes stale or random
  task automatic pick_handle(output logic [5:0] s, output logic [31:0] g);
    int k;
    k = $urandom_range(0, 9);
    if (n_live > 0 && k < 6) begin
      s = slot_at[$urandom_range(0, n_live - 1)];
      g = gen_of[s];
    end else if (k < 8) begin
      s = 6'($urandom_range(0, CAP - 1));
      g = gen_of[s] - 32'd1;
    end else begin
      s = 6'($urandom_range(0, CAP - 1));
      g = $urandom();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    gsa_pkg::res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok             = out_tdata[0];
      got.out_slot       = out_tdata[6:1];
      got.out_generation = out_tdata[38:7];
      got.out_dense_pos  = out_tdata[44:39];
      got.move_from      = out_tdata[50:45];
      got.move_to        = out_tdata[56:51];
      got.moved          = out_tuser[0];
      got.last           = out_tlast;
      n_res++;
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        n_err++;
      end else begin
        want = exp_q.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          n_err++;
        end
      end
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  initial begin
    int ph;
    out_tready = 1'b0;
    ph = 0;
    forever begin
      @(negedge clk);
      ph++;
      if (hold_long) out_tready <= 1'b0;
      else if (!rx_pattern_on) out_tready <= 1'b1;
      else out_tready <= (ph % 7 < 4) || ($urandom_range(0, 2) == 0);
    end
  end

  task automatic test_spawn_fill();
    for (int i = 0; i < 3; i++) send_op(gsa_pkg::ACT_SPAWN, 6'd0, 32'd0, 6'd0);
    send_op(gsa_pkg::ACT_AT, 6'd0, 32'd0, 6'd63);
    send_op(gsa_pkg::ACT_AT, 6'd0, 32'd0, 6'd0);
    send_op(gsa_pkg::ACT_POS, 6'd1, 32'd1, 6'd0);
    send_op(gsa_pkg::ACT_POS, 6'd63, 32'hFFFF_FFFF, 6'd63);
    send_op(gsa_pkg::ACT_PEND, 6'd2, 32'd1, 6'd0);
    send_op(ACT_SPARE_A, 6'h3F, 32'hFFFF_FFFF, 6'h3F);
    send_op(ACT_SPARE_B, 6'd0, 32'd0, 6'd0);
    drain();
  endtask

  task automatic test_destroy_compact();
    send_op(gsa_pkg::ACT_COMPACT, 6'd0, 32'd0, 6'd0);  // nothing pending
    send_op(gsa_pkg::ACT_DESTROY, 6'd0, 32'd1, 6'd0);
    send_op(gsa_pkg::ACT_DESTROY, 6'd0, 32'd1, 6'd0);  // already pending
    send_op(gsa_pkg::ACT_DESTROY, 6'd5, 32'd1, 6'd0);  // never spawned
    send_op(gsa_pkg::ACT_DESTROY, 6'd1, 32'd2, 6'd0);  // wrong generation
    send_op(gsa_pkg::ACT_PEND, 6'd0, 32'd1, 6'd0);
    send_op(gsa_pkg::ACT_DESTROY, 6'd2, 32'd1, 6'd0);  // last position, no move
    send_op(gsa_pkg::ACT_COMPACT, 6'd0, 32'd0, 6'd0);
    send_op(gsa_pkg::ACT_POS, 6'd0, 32'd1, 6'd0);      // stale now
    send_op(gsa_pkg::ACT_SPAWN, 6'd0, 32'd0, 6'd0);
    drain();
  endtask

  // fill to capacity while the receiver holds off, then spawn when full
  task automatic test_full_backpressure();
    hold_long = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_long = 0;
      end
      while (n_live < CAP) send_op(gsa_pkg::ACT_SPAWN, 6'd0, 32'd0, 6'd0);
    join
    send_op(gsa_pkg::ACT_SPAWN, 6'd0, 32'd0, 6'd0);
    for (int p = 0; p < CAP; p += 2)
      send_op(gsa_pkg::ACT_DESTROY, slot_at[p], gen_of[slot_at[p]], 6'd0);
    send_op(gsa_pkg::ACT_COMPACT, 6'd0, 32'd0, 6'd0);
    drain();
  endtask

  task automatic test_random_mix(int count);
    logic [5:0] s;
    logic [31:0] g;
    int k;
    rx_pattern_on = 1;
    for (int i = 0; i < count; i++) begin
      maybe_gap();
      k = $urandom_range(0, 99);
      pick_handle(s, g);
      if (k < 30) send_op(gsa_pkg::ACT_SPAWN, 6'($urandom()), $urandom(), 6'($urandom()));
      else if (k < 52) send_op(gsa_pkg::ACT_DESTROY, s, g, 6'($urandom()));
      else if (k < 64) send_op(gsa_pkg::ACT_POS, s, g, 6'($urandom()));
      else if (k < 76) send_op(gsa_pkg::ACT_AT, 6'($urandom()), $urandom(),
                               6'($urandom_range(0, n_live + 2 > 63 ? 63 : n_live + 2)));
      else if (k < 86) send_op(gsa_pkg::ACT_PEND, s, g, 6'($urandom()));
      else if (k < 96) send_op(gsa_pkg::ACT_COMPACT, 6'($urandom()), $urandom(),
                               6'($urandom()));
      else send_op(($urandom_range(0, 1) != 0) ? ACT_SPARE_B : ACT_SPARE_A,
                   6'($urandom()), $urandom(), 6'($urandom()));
      if (i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    hold_long = 0; rx_pattern_on = 0;
    n_err = 0; n_items = 0; n_res = 0; n_moves = 0; n_spawn_full = 0;
    for (int i = 0; i < CAP; i++) begin
      gen_of[i] = 1; pos_of[i] = NO_POS; slot_at[i] = 0; pend[i] = 0;
      free_stk[i] = 6'(CAP - 1 - i);
    end
    n_free = CAP; n_live = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_spawn_fill();
    test_destroy_compact();
    test_full_backpressure();
    test_random_mix(115);
    $display("covered %0d transactions in, %0d results, %0d compact moves, %0d full spawns",
             n_items, n_res, n_moves, n_spawn_full);
    if (n_err == 0 && exp_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
